@@ rtl/cmav_pkg.sv @@
// Shared constants, payload structs and lane control struct for the centred moving average.
package cmav_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 15;
    localparam int SAMPLE_BITS        = 16;
    localparam int HALF_WIDTH_BITS    = 4;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic signed [SAMPLE_BITS-1:0] sample_z;
        logic                          end_of_stream;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_x;
        logic signed [SAMPLE_BITS-1:0] mean_y;
        logic signed [SAMPLE_BITS-1:0] mean_z;
        logic                          final_result;
    } result_t;

    // Per-cycle commands from the controller to the three axis lanes.
    typedef struct packed {
        logic push;
        logic zero_in;
        logic clear;
        logic sweep_clr;
        logic sweep_add;
        logic p1_load;
        logic p2_load;
    } lane_ctrl_t;

endpackage

@@ rtl/cmav_lane.sv @@
// One axis lane: window shift line, running window sum and reciprocal divide.
module cmav_lane
    import cmav_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  lane_ctrl_t                                ctrl,
    input  logic signed [SAMPLE_BITS-1:0]             sample,
    input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]       hw,
    input  logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]     sweep_idx,
    input  logic [SAMPLE_BITS+$clog2(2*MAX_HALF_WIDTH+1)
                  +$clog2(2*MAX_HALF_WIDTH+2):0]      recip,
    output logic signed [SAMPLE_BITS-1:0]             mean
);

    localparam int STORE_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int IDX_BITS    = $clog2(STORE_DEPTH);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(STORE_DEPTH);
    localparam int SHIFT       = SUM_BITS + $clog2(STORE_DEPTH + 1);
    localparam int RECIP_BITS  = SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    logic signed [SAMPLE_BITS-1:0] line_reg [STORE_DEPTH];
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic signed [SUM_BITS-1:0]    acc_reg;
    logic [PROD_BITS-1:0]          prod_reg;
    logic                          neg_reg;

    logic signed [SAMPLE_BITS-1:0] new_val;
    logic signed [SAMPLE_BITS-1:0] old_val;
    logic signed [SUM_BITS-1:0]    sum_push;
    logic [SUM_BITS-1:0]           mag;
    logic [SAMPLE_BITS-1:0]        quot;

    // The entry at 2*hw leaves the window when the line shifts.
    assign new_val  = ctrl.zero_in ? '0 : sample;
    assign old_val  = line_reg[IDX_BITS'({hw, 1'b0})];
    assign sum_push = sum_reg + SUM_BITS'(new_val) - SUM_BITS'(old_val);
    assign mag      = acc_reg[SUM_BITS-1] ? SUM_BITS'(-acc_reg) : SUM_BITS'(acc_reg);
    assign quot     = prod_reg[SHIFT +: SAMPLE_BITS];
    assign mean     = neg_reg ? -$signed(quot) : $signed(quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else if (ctrl.push)
        begin
            for (int i = 1; i < STORE_DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
            line_reg[0] <= new_val;
            sum_reg     <= sum_push;
        end
        else if (ctrl.sweep_clr)
        begin
            sum_reg <= '0;
        end
        else if (ctrl.sweep_add)
        begin
            sum_reg <= sum_reg + SUM_BITS'(line_reg[sweep_idx]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.p1_load)
        begin
            acc_reg <= sum_push;
        end
        if (ctrl.p2_load)
        begin
            prod_reg <= PROD_BITS'(mag) * PROD_BITS'(recip);
            neg_reg  <= acc_reg[SUM_BITS-1];
        end
    end

endmodule

@@ rtl/cmav_merge.sv @@
// Output stage: gathers the three lane means and the end marker into the result register.
module cmav_merge
    import cmav_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] mean_x,
    input  logic signed [SAMPLE_BITS-1:0] mean_y,
    input  logic signed [SAMPLE_BITS-1:0] mean_z,
    input  logic                          final_in,
    input  logic                          result_stall,
    output logic                          result_valid,
    output result_t                       result
);

    logic    valid_reg;
    result_t data_reg;

    assign result_valid = valid_reg;
    assign result       = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg.mean_x       <= mean_x;
            data_reg.mean_y       <= mean_y;
            data_reg.mean_z       <= mean_z;
            data_reg.final_result <= final_in;
        end
    end

endmodule

@@ rtl/centered_moving_average_3axis.sv @@
// Top level of the three-axis centred moving average: control, reciprocal table and lanes.
//
// Each accepted sample is shifted into a window line of 2*MAX_HALF_WIDTH+1 entries per axis,
// and each axis keeps a running sum of the newest 2*half_width+1 entries, updated by adding
// the new sample and dropping the one that leaves the window. The three axes run in separate
// lanes side by side; the sum is divided by the window width through a multiply by a constant
// reciprocal (exact for every reachable sum) and the merge stage packs the three means into the
// result register. A plain sample is one window push; an end-of-stream sample is followed by
// half_width pushes of zeros, which flush the pending results and may be held by a stall; the
// last result of a stream carries final_result and the window, the sums and the counter are
// then cleared. Each result is registered in the first divider stage, then the second, then
// the output register. The block stalls the sample side while a flush or rebuild runs, or while
// its result register is held by result_stall and the two divider stages are full. A write of
// half_width (values above MAX_HALF_WIDTH are clamped) rebuilds the running sums from the
// stored window, one entry per cycle, during which no sample transaction is taken; write it
// only when the block is idle. The first half_width samples of a stream give no result.
module centered_moving_average_3axis
    import cmav_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  sample_t                    sample,
    output logic                       result_valid,
    input  logic                       result_stall,
    output result_t                    result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [HALF_WIDTH_BITS-1:0] cfg_half_width
);

    localparam int STORE_DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int HW_BITS     = $clog2(MAX_HALF_WIDTH + 1);
    localparam int IDX_BITS    = $clog2(STORE_DEPTH);
    localparam int CNT_BITS    = $clog2(STORE_DEPTH + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + $clog2(STORE_DEPTH);
    localparam int SHIFT       = SUM_BITS + $clog2(STORE_DEPTH + 1);
    localparam int RECIP_BITS  = SHIFT + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_SWEEP
    } state_t;

    state_t                  state_reg,     state_next;
    logic [CNT_BITS-1:0]     cnt_reg,       cnt_next;
    logic [HW_BITS-1:0]      flush_cnt_reg, flush_cnt_next;
    logic [IDX_BITS-1:0]     sweep_idx_reg, sweep_idx_next;
    logic [HW_BITS-1:0]      hw_reg,        hw_next;
    logic [RECIP_BITS-1:0]   recip_reg,     recip_next;
    logic                    p1_valid_reg,  p1_valid_next;
    logic                    p1_final_reg,  p1_final_next;
    logic                    p2_valid_reg,  p2_valid_next;
    logic                    p2_final_reg,  p2_final_next;

    logic [RECIP_BITS-1:0]   recip_tab [MAX_HALF_WIDTH+1];
    logic [HW_BITS-1:0]      hw_cfg;
    logic [CNT_BITS-1:0]     cnt_inc;
    logic                    p2_move;
    logic                    p1_move;
    logic                    push_ok;
    logic                    accept;
    logic                    flush_push;
    logic                    push;
    logic                    last;
    logic                    emit;
    logic                    cfg_write;
    lane_ctrl_t              lane_ctrl;

    logic signed [SAMPLE_BITS-1:0] lane_mean [3];
    logic signed [SAMPLE_BITS-1:0] lane_in   [3];

    // Reciprocals ceil(2^SHIFT / w) for every window width w = 2h+1, worked out at elaboration.
    for (genvar g = 0; g <= MAX_HALF_WIDTH; g++)
    begin : g_recip
        localparam logic [63:0] WIDTH = 64'(2 * g + 1);
        localparam logic [63:0] RV    = ((64'd1 << SHIFT) + WIDTH - 64'd1) / WIDTH;
        assign recip_tab[g] = RECIP_BITS'(RV);
    end

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign hw_cfg    = (32'(cfg_half_width) > 32'(MAX_HALF_WIDTH)) ?
                       HW_BITS'(MAX_HALF_WIDTH) : HW_BITS'(cfg_half_width);

    // A stage may advance when the stage after it is empty or empties in the same cycle.
    assign p2_move      = p2_valid_reg && (!result_valid || !result_stall);
    assign p1_move      = p1_valid_reg && (!p2_valid_reg || p2_move);
    assign push_ok      = !p1_valid_reg || p1_move;
    assign sample_stall = !((state_reg == S_IDLE) && push_ok);
    assign accept       = sample_valid && !sample_stall;
    assign flush_push   = (state_reg == S_FLUSH) && push_ok;
    assign push         = accept || flush_push;

    // The last push of a transaction clears the stream; once results start every push emits,
    // so the last push carries the final result whenever the stream produced any.
    assign last    = (accept && sample.end_of_stream && (hw_reg == '0))
                  || (flush_push && (flush_cnt_reg == HW_BITS'(1)));
    assign cnt_inc = (cnt_reg == CNT_BITS'(STORE_DEPTH)) ? cnt_reg : cnt_reg + CNT_BITS'(1);
    assign emit    = push && (cnt_inc > CNT_BITS'(hw_reg));

    always_comb
    begin
        lane_ctrl.push      = push;
        lane_ctrl.zero_in   = flush_push;
        lane_ctrl.clear     = push && last;
        lane_ctrl.sweep_clr = cfg_write;
        lane_ctrl.sweep_add = (state_reg == S_SWEEP) && !cfg_write;
        lane_ctrl.p1_load   = emit;
        lane_ctrl.p2_load   = p1_move;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        flush_cnt_next = flush_cnt_reg;
        sweep_idx_next = sweep_idx_reg;
        hw_next        = hw_reg;
        recip_next     = recip_reg;
        p1_valid_next  = p1_valid_reg;
        p1_final_next  = p1_final_reg;
        p2_valid_next  = p2_valid_reg;
        p2_final_next  = p2_final_reg;

        if (push)
        begin
            cnt_next = last ? '0 : cnt_inc;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && sample.end_of_stream && (hw_reg != '0))
                begin
                    state_next     = S_FLUSH;
                    flush_cnt_next = hw_reg;
                end
            end
            S_FLUSH:
            begin
                if (flush_push)
                begin
                    flush_cnt_next = flush_cnt_reg - HW_BITS'(1);
                    if (last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SWEEP:
            begin
                sweep_idx_next = sweep_idx_reg + IDX_BITS'(1);
                if (sweep_idx_reg == IDX_BITS'({hw_reg, 1'b0}))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            state_next     = S_SWEEP;
            sweep_idx_next = '0;
            hw_next        = hw_cfg;
            recip_next     = recip_tab[hw_cfg];
        end

        if (emit)
        begin
            p1_valid_next = 1'b1;
            p1_final_next = last;
        end
        else if (p1_move)
        begin
            p1_valid_next = 1'b0;
        end

        if (p1_move)
        begin
            p2_valid_next = 1'b1;
            p2_final_next = p1_final_reg;
        end
        else if (p2_move)
        begin
            p2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            flush_cnt_reg <= '0;
            sweep_idx_reg <= '0;
            hw_reg        <= '0;
            recip_reg     <= recip_tab[0];
            p1_valid_reg  <= 1'b0;
            p1_final_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p2_final_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            flush_cnt_reg <= flush_cnt_next;
            sweep_idx_reg <= sweep_idx_next;
            hw_reg        <= hw_next;
            recip_reg     <= recip_next;
            p1_valid_reg  <= p1_valid_next;
            p1_final_reg  <= p1_final_next;
            p2_valid_reg  <= p2_valid_next;
            p2_final_reg  <= p2_final_next;
        end
    end

    assign lane_in[0] = sample.sample_x;
    assign lane_in[1] = sample.sample_y;
    assign lane_in[2] = sample.sample_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        cmav_lane #(
            .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (lane_ctrl),
            .sample    (lane_in[a]),
            .hw        (hw_reg),
            .sweep_idx (sweep_idx_reg),
            .recip     (recip_reg),
            .mean      (lane_mean[a])
        );
    end

    cmav_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (p2_move),
        .mean_x       (lane_mean[0]),
        .mean_y       (lane_mean[1]),
        .mean_z       (lane_mean[2]),
        .final_in     (p2_final_reg),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

    // A push must never overwrite a result that is still waiting in the first divider stage.
    a_no_p1_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!p1_valid_reg || p1_move))
        else $error("window push while first divider stage is blocked");

    // The second divider stage only takes a result when it is empty or can hand its own on.
    a_no_p2_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        p1_move |-> (!p2_valid_reg || p2_move))
        else $error("second divider stage overwritten");

    // The sums are being rebuilt, so the window must not move.
    a_no_push_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !push)
        else $error("window push during sum rebuild");

    // A flush always has zeros left to push.
    a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) |-> (flush_cnt_reg != '0))
        else $error("flush entered with nothing to push");

    // The end of a stream leaves the position count at zero for the next one.
    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.clear |=> (cnt_reg == '0))
        else $error("position count not cleared after end of stream");

endmodule
